// ----- src/srtl_pkg.sv -----
// ----------------------------------------------------------------------------
// srtl_pkg
// Types, codes and helpers shared by the sorted range table lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srtl_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Response status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SKIPPED   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] range_base;
    logic [31:0] range_size;
    logic        is_text;
    logic [63:0] lookup_address;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found_index;
  } rsp_t;

  typedef struct packed {
    logic [63:0] base;
    logic [31:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHECK,
    S_SHIFT,
    S_SHIFT_LAST,
    S_INSERT,
    S_RESP
  } state_t;

  // True when addr lies at or beyond base + size. The end carries into a
  // 65th bit, so a range that reaches past the top never wraps.
  function automatic logic at_or_past_end(input logic [63:0] addr,
                                          input entry_t      ent);
    logic [64:0] end_sum;
    end_sum = {1'b0, ent.base} + {33'b0, ent.size};
    return {1'b0, addr} >= end_sum;
  endfunction

endpackage

// ----- src/srtl_mem.sv -----
// ----------------------------------------------------------------------------
// srtl_mem
// Range table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srtl_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output srtl_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  srtl_pkg::entry_t wr_data
);
  import srtl_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/srtl_ctrl.sv -----
// ----------------------------------------------------------------------------
// srtl_ctrl
// Sequencer: binary search over the table memory, insertion sweep for loads,
// final range check for lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srtl_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IW          = 10,
  parameter int CW          = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  srtl_pkg::req_t   req,
  input  logic             slot_free,
  output logic             res_load,
  output srtl_pkg::rsp_t   res,
  output logic             mem_rd_en,
  output logic [IW-1:0]    mem_rd_addr,
  input  srtl_pkg::entry_t mem_rd_data,
  output logic             mem_wr_en,
  output logic [IW-1:0]    mem_wr_addr,
  output srtl_pkg::entry_t mem_wr_data
);
  import srtl_pkg::*;

  state_t        state, state_next;
  req_t          item, item_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [IW-1:0] waddr, waddr_next;
  logic          wpend, wpend_next;
  rsp_t          result, result_next;
  logic [CW-1:0] mid_calc;
  logic          go_right;

  assign res = result;

  always_comb begin
    state_next  = state;
    item_next   = item;
    count_next  = count;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    ptr_next    = ptr;
    waddr_next  = waddr;
    wpend_next  = wpend;
    result_next = result;
    req_stall   = (state != S_IDLE);
    res_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = IW'(mid);
    mem_wr_en   = 1'b0;
    mem_wr_addr = waddr;
    mem_wr_data = mem_rd_data;
    mid_calc    = lo + ((hi - lo) >> 1);
    go_right    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          item_next   = req;
          lo_next     = '0;
          hi_next     = count;
          result_next = '{status: ST_OK, found_index: '0};
          unique case (req.opcode)
            OP_CLEAR: begin
              count_next = '0;
              state_next = S_RESP;
            end
            OP_LOAD: begin
              // The skip check takes precedence over the full check.
              if (!req.is_text || (req.range_size == 32'd0)) begin
                result_next.status = ST_SKIPPED;
                state_next         = S_RESP;
              end else if (count == CW'(TABLE_DEPTH)) begin
                result_next.status = ST_FULL;
                state_next         = S_RESP;
              end else begin
                state_next = S_SEARCH;
              end
            end
            OP_LOOKUP: begin
              state_next = S_SEARCH;
            end
            default: begin
              result_next.status = ST_SKIPPED;
              state_next         = S_RESP;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (lo < hi) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = IW'(mid_calc);
          mid_next    = mid_calc;
          state_next  = S_CMP;
        end else if (item.opcode == OP_LOAD) begin
          if (lo < count) begin
            ptr_next   = count - 1'b1;
            wpend_next = 1'b0;
            state_next = S_SHIFT;
          end else begin
            state_next = S_INSERT;
          end
        end else if (lo < count) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = IW'(lo);
          state_next  = S_CHECK;
        end else begin
          result_next.status = ST_NOT_FOUND;
          state_next         = S_RESP;
        end
      end

      S_CMP: begin
        // Loads look for the first base strictly above the new one; lookups
        // look for the first range whose end lies above the address.
        if (item.opcode == OP_LOAD) begin
          go_right = (mem_rd_data.base <= item.range_base);
        end else begin
          go_right = at_or_past_end(item.lookup_address, mem_rd_data);
        end
        if (go_right) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end

      S_CHECK: begin
        if ((item.lookup_address >= mem_rd_data.base) &&
            !at_or_past_end(item.lookup_address, mem_rd_data)) begin
          result_next.found_index = 10'(lo);
        end else begin
          result_next.status = ST_NOT_FOUND;
        end
        state_next = S_RESP;
      end

      S_SHIFT: begin
        // Walk down from the last entry; each word read here is written one
        // slot higher in the next cycle.
        mem_rd_en   = 1'b1;
        mem_rd_addr = IW'(ptr);
        mem_wr_en   = wpend;
        waddr_next  = IW'(ptr + 1'b1);
        wpend_next  = 1'b1;
        if (ptr == lo) begin
          state_next = S_SHIFT_LAST;
        end else begin
          ptr_next = ptr - 1'b1;
        end
      end

      S_SHIFT_LAST: begin
        mem_wr_en  = 1'b1;
        state_next = S_INSERT;
      end

      S_INSERT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = IW'(lo);
        mem_wr_data = '{base: item.range_base, size: item.range_size};
        count_next  = count + 1'b1;
        state_next  = S_RESP;
      end

      S_RESP: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      wpend <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      wpend <= wpend_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    ptr    <= ptr_next;
    waddr  <= waddr_next;
    result <= result_next;
  end

endmodule

// ----- src/sorted_range_table_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_range_table_lookup_unit
// Address range table kept sorted by base, with clear, load and lookup.
// ----------------------------------------------------------------------------
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-----------------------------------------
//   request | req_valid | req_stall | req (opcode, range, lookup address)
//   result  | rsp_valid | rsp_stall | rsp (status, found_index)
//
// One word is handled at a time. Each binary search step over the n entries
// has an address and a compare phase. A clear or rejected load goes straight to
// the result; a lookup then reads and checks the entry found, if any entry ends
// above the address; a load sweeps the n - pos entries at and above its slot pos
// up one slot, none when pos = n, and then writes the new entry.
// The single read port of the table memory sets the search and sweep pace.
// Reset empties the table at once; entries beyond the count are never read.
// A pending result sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_range_table_lookup_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  srtl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output srtl_pkg::rsp_t rsp
);
  import srtl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          slot_free;
  logic          res_load;
  rsp_t          res;
  logic          mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;

  assign slot_free = !rsp_valid || !rsp_stall;

  srtl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .slot_free   (slot_free),
    .res_load    (res_load),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  srtl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp <= res;
    end
  end

endmodule

// ----- src/srtl_checker.sv -----
// ----------------------------------------------------------------------------
// srtl_checker
// Port-level checks for the sorted range table lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srtl_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input srtl_pkg::rsp_t rsp
);
  import srtl_pkg::*;

  // A held result word keeps its value until taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // Only a successful lookup carries an index.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.found_index == 10'd0)
    else $error("nonzero index on a result without a match");

  // The unit works on one request word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while a word is still in progress");

endmodule

bind sorted_range_table_lookup_unit srtl_checker u_srtl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
